>>> src/osp_pkg.sv
// Shared types and constants for the one-way speed PID assist block.
// Holds configuration layout, register codes, datapath widths and defaults.
// No dependencies.
package osp_pkg;

    // Configuration port geometry.
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_KP     = 3'd0;
    localparam logic [2:0] REG_KI     = 3'd1;
    localparam logic [2:0] REG_KD     = 3'd2;
    localparam logic [2:0] REG_DIR    = 3'd3;
    localparam logic [2:0] REG_NEGCMD = 3'd4;
    localparam logic [2:0] REG_NEGFB  = 3'd5;
    localparam logic [2:0] REG_START  = 3'd6;
    localparam logic [2:0] REG_LIMIT  = 3'd7;

    // Register reset values.
    localparam logic [15:0] KP_RST     = 16'd384;
    localparam logic [15:0] KI_RST     = 16'd154;
    localparam logic [15:0] KD_RST     = 16'd0;
    localparam logic [7:0]  DIR_RST    = 8'd0;
    localparam logic        NEGCMD_RST = 1'b1;
    localparam logic        NEGFB_RST  = 1'b0;
    localparam logic [13:0] START_RST  = 14'd100;
    localparam logic [13:0] LIMIT_RST  = 14'd3500;

    // Defaults for the top-level parameters.
    localparam int unsigned STEP_RATIO_Q8_DEF = 2962;
    localparam int unsigned DEADBAND_Q8_DEF   = 256;
    localparam int unsigned MAX_DT_MS_DEF     = 50;

    // Datapath widths, sized for the full ranges of fields and parameters.
    localparam int unsigned MC_W   = 44;  // multiplicand: up to |deriv|
    localparam int unsigned MP_W   = 26;  // multiplier: up to ki*dt
    localparam int unsigned PROD_W = 64;
    localparam int unsigned DVD_W  = 58;  // dividend: |err|*ki*dt
    localparam int unsigned DVS_W  = 10;  // divisor: 1000 or dt
    localparam int unsigned ERR_W  = 33;
    localparam int unsigned DIFF_W = 34;
    localparam int unsigned INT_W  = 30;  // integral, 0..limit<<16
    localparam int unsigned SUM_W  = 64;

    localparam logic [DVS_W-1:0] MS_PER_S = 10'd1000;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
        logic [7:0]  dir;
        logic        neg_cmd;
        logic        neg_fb;
        logic [13:0] start;
        logic [13:0] limit;
    } cfg_t;

endpackage

>>> src/osp_mul.sv
// Bit-serial shift-and-add multiplier for the PID assist datapath.
// Consumes one multiplier bit per cycle, stops early when no bits remain.
// Depends on osp_pkg.
module osp_mul (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [osp_pkg::MC_W-1:0]   mcand,
    input  logic [osp_pkg::MP_W-1:0]   mplier,
    output logic                       busy,
    output logic [osp_pkg::PROD_W-1:0] prod
);

    logic [osp_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic [osp_pkg::PROD_W-1:0] mc_reg, mc_next;
    logic [osp_pkg::MP_W-1:0]   mp_reg, mp_next;
    logic                       busy_reg, busy_next;

    // One partial product per cycle, multiplier shifted out LSB first.
    always_comb begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        busy_next = busy_reg;
        if (start) begin
            acc_next  = '0;
            mc_next   = osp_pkg::PROD_W'(mcand);
            mp_next   = mplier;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (mp_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                if (mp_reg[0]) begin
                    acc_next = acc_reg + mc_reg;
                end
                mc_next = mc_reg << 1;
                mp_next = mp_reg >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign busy = busy_reg;
    assign prod = acc_reg;

endmodule

>>> src/osp_div.sv
// Restoring radix-2 divider for the PID assist datapath.
// Produces one quotient bit per cycle over the full dividend width.
// Depends on osp_pkg.
module osp_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [osp_pkg::DVD_W-1:0] dividend,
    input  logic [osp_pkg::DVS_W-1:0] divisor,
    output logic                      busy,
    output logic [osp_pkg::DVD_W-1:0] quo
);

    localparam int unsigned CNT_W = $clog2(osp_pkg::DVD_W + 1);

    logic [osp_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [osp_pkg::DVD_W-1:0] quo_reg, quo_next;
    logic [osp_pkg::DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic [osp_pkg::DVS_W:0]   shifted;
    logic [osp_pkg::DVS_W:0]   diff;

    // Shift in the next dividend bit and subtract when the divisor fits.
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg, quo_reg[osp_pkg::DVD_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(osp_pkg::DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = diff[osp_pkg::DVS_W-1:0];
                quo_next = {quo_reg[osp_pkg::DVD_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[osp_pkg::DVS_W-1:0];
                quo_next = {quo_reg[osp_pkg::DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

>>> src/osp_cfg.sv
// APB-style register file for the PID assist gains, limits and polarity.
// Writes land on the access beat; reads return the stored values.
// Depends on osp_pkg.
module osp_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [osp_pkg::ADDR_W-1:0] paddr,
    input  logic [osp_pkg::DATA_W-1:0] pwdata,
    output logic [osp_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output osp_pkg::cfg_t              cfg
);

    osp_pkg::cfg_t cfg_reg, cfg_next;
    logic [2:0]    idx;
    logic          wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register write decode, values masked to the register width.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                osp_pkg::REG_KP:     cfg_next.kp      = pwdata[15:0];
                osp_pkg::REG_KI:     cfg_next.ki      = pwdata[15:0];
                osp_pkg::REG_KD:     cfg_next.kd      = pwdata[15:0];
                osp_pkg::REG_DIR:    cfg_next.dir     = pwdata[7:0];
                osp_pkg::REG_NEGCMD: cfg_next.neg_cmd = pwdata[0];
                osp_pkg::REG_NEGFB:  cfg_next.neg_fb  = pwdata[0];
                osp_pkg::REG_START:  cfg_next.start   = pwdata[13:0];
                osp_pkg::REG_LIMIT:  cfg_next.limit   = pwdata[13:0];
                default:             cfg_next         = cfg_reg;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (idx)
            osp_pkg::REG_KP:     prdata = 32'(cfg_reg.kp);
            osp_pkg::REG_KI:     prdata = 32'(cfg_reg.ki);
            osp_pkg::REG_KD:     prdata = 32'(cfg_reg.kd);
            osp_pkg::REG_DIR:    prdata = 32'(cfg_reg.dir);
            osp_pkg::REG_NEGCMD: prdata = 32'(cfg_reg.neg_cmd);
            osp_pkg::REG_NEGFB:  prdata = 32'(cfg_reg.neg_fb);
            osp_pkg::REG_START:  prdata = 32'(cfg_reg.start);
            osp_pkg::REG_LIMIT:  prdata = 32'(cfg_reg.limit);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp      <= osp_pkg::KP_RST;
            cfg_reg.ki      <= osp_pkg::KI_RST;
            cfg_reg.kd      <= osp_pkg::KD_RST;
            cfg_reg.dir     <= osp_pkg::DIR_RST;
            cfg_reg.neg_cmd <= osp_pkg::NEGCMD_RST;
            cfg_reg.neg_fb  <= osp_pkg::NEGFB_RST;
            cfg_reg.start   <= osp_pkg::START_RST;
            cfg_reg.limit   <= osp_pkg::LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/one_way_speed_pid_assist.sv
// One-way speed PID assist: top level with the tick sequencer and PID state.
// Instantiates osp_cfg, osp_mul and osp_div; depends on osp_pkg.
//
// One tick is taken at a time. A tick that does not engage assist (direction
// differs from descend_direction or zero step speed) clears the PID state and
// yields its zero result via S_FIN once the output register is free. An
// engaged tick runs on one bit-serial multiplier and one restoring divider,
// its time dominated by the divisions over the full 58-bit dividend: the
// integral by 1000 and, when dt is nonzero, the derivative by dt. The result waits
// in an output register, so the next input beat is taken while it is pending.
module one_way_speed_pid_assist #(
    parameter int unsigned STEP_RATIO_Q8 = osp_pkg::STEP_RATIO_Q8_DEF,
    parameter int unsigned DEADBAND_Q8   = osp_pkg::DEADBAND_Q8_DEF,
    parameter int unsigned MAX_DT_MS     = osp_pkg::MAX_DT_MS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // tick_time_ms[31:0], step_direction[39:32], step_speed[63:40],
    // motor_speed_raw[79:64]
    input  logic [79:0]                s_tdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // drive_current[14:0], target_speed[45:15], zero fill [47:46]
    output logic [47:0]                m_tdata,
    // assist_active[0]
    output logic                       m_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [osp_pkg::ADDR_W-1:0] paddr,
    input  logic [osp_pkg::DATA_W-1:0] pwdata,
    output logic [osp_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int unsigned V_W = osp_pkg::DVD_W + 2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TGT  = 4'd1;
    localparam logic [3:0] S_ERR  = 4'd2;
    localparam logic [3:0] S_IMUL = 4'd3;
    localparam logic [3:0] S_IDIV = 4'd4;
    localparam logic [3:0] S_DMUL = 4'd5;
    localparam logic [3:0] S_DDIV = 4'd6;
    localparam logic [3:0] S_KD   = 4'd7;
    localparam logic [3:0] S_KP   = 4'd8;
    localparam logic [3:0] S_CLMP = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    localparam logic [osp_pkg::MP_W-1:0] RATIO = osp_pkg::MP_W'(STEP_RATIO_Q8);
    localparam logic [osp_pkg::DVS_W-1:0] MAX_DT = osp_pkg::DVS_W'(MAX_DT_MS);
    localparam logic signed [osp_pkg::ERR_W-1:0] DB = osp_pkg::ERR_W'(DEADBAND_Q8);

    osp_pkg::cfg_t cfg;

    // Sequencer and tick registers.
    logic [3:0]  state_reg, state_next;
    logic        go_reg, go_next;
    logic [31:0] now_reg, now_next;
    logic [23:0] sspeed_reg, sspeed_next;
    logic [15:0] raw_reg, raw_next;
    logic        active_reg, active_next;
    logic [30:0] tgt_reg, tgt_next;
    logic [osp_pkg::DVS_W-1:0] dt_reg, dt_next;
    logic signed [osp_pkg::ERR_W-1:0] err_reg, err_next;
    logic [osp_pkg::MP_W-1:0] kidt_reg, kidt_next;
    logic signed [osp_pkg::DIFF_W-1:0] diff_reg, diff_next;
    logic signed [osp_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [osp_pkg::INT_W-1:0] outq_reg, outq_next;

    // PID state carried between ticks.
    logic [osp_pkg::INT_W-1:0] integ_reg, integ_next;
    logic signed [osp_pkg::ERR_W-1:0] prev_err_reg, prev_err_next;
    logic [31:0] prev_tick_reg, prev_tick_next;
    logic        prev_valid_reg, prev_valid_next;

    // Output register.
    logic        m_tvalid_reg, m_tvalid_next;
    logic [47:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;

    // Arithmetic units.
    logic                           mul_start, mul_busy;
    logic [osp_pkg::MC_W-1:0]       mul_mcand;
    logic [osp_pkg::MP_W-1:0]       mul_mplier;
    logic [osp_pkg::PROD_W-1:0]     mul_prod;
    logic                           div_start, div_busy;
    logic [osp_pkg::DVS_W-1:0]      div_divisor;
    logic [osp_pkg::DVD_W-1:0]      div_quo;

    // Combinational helpers.
    logic                           eng_in;
    logic [31:0]                    tgt_full;
    logic [30:0]                    tgt_sat;
    logic [31:0]                    dt_raw;
    logic [osp_pkg::DVS_W-1:0]      dt_new;
    logic signed [24:0]             meas_pos, meas;
    logic signed [osp_pkg::ERR_W-1:0] err_raw, err_db, err_neg;
    logic [31:0]                    abs_err;
    logic signed [osp_pkg::DIFF_W-1:0] diff_neg;
    logic [32:0]                    abs_diff;
    logic [osp_pkg::INT_W-1:0]      lim;
    logic signed [V_W-1:0]          integ_v, quo_v, lim_v, integ_sum;
    logic [osp_pkg::INT_W-1:0]      integ_new;
    logic signed [osp_pkg::SUM_W-1:0] prod_s, lim_s;
    logic [30:0]                    rnd;
    logic [14:0]                    mag, mag_fl, cur;

    osp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    osp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .busy    (mul_busy),
        .prod    (mul_prod)
    );

    osp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mul_prod[osp_pkg::DVD_W-1:0]),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quo      (div_quo)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign eng_in   = (s_tdata[39:32] == cfg.dir) && (s_tdata[63:40] != 24'd0);

    // Target: ratio times step speed, drop the extra fraction, saturate.
    assign tgt_full = mul_prod[39:8];
    assign tgt_sat  = tgt_full[31] ? 31'h7FFF_FFFF : tgt_full[30:0];

    // Elapsed time since the last engaged tick, clamped.
    assign dt_raw = now_reg - prev_tick_reg;
    always_comb begin
        if (!prev_valid_reg) begin
            dt_new = '0;
        end else if (dt_raw > 32'(MAX_DT_MS)) begin
            dt_new = MAX_DT;
        end else begin
            dt_new = dt_raw[osp_pkg::DVS_W-1:0];
        end
    end

    // Speed error with feedback polarity and deadband.
    assign meas_pos = $signed({{1{raw_reg[15]}}, raw_reg, 8'd0});
    assign meas     = cfg.neg_fb ? -meas_pos : meas_pos;
    assign err_raw  = $signed({2'b00, tgt_reg}) - $signed({{8{meas[24]}}, meas});
    assign err_db   = (err_raw > -DB && err_raw < DB) ? '0 : err_raw;
    assign err_neg  = -err_reg;
    assign abs_err  = err_reg[osp_pkg::ERR_W-1] ? err_neg[31:0] : err_reg[31:0];
    assign diff_neg = -diff_reg;
    assign abs_diff = diff_reg[osp_pkg::DIFF_W-1] ? diff_neg[32:0] : diff_reg[32:0];

    // Integral update, clamped to 0..limit.
    assign lim       = {cfg.limit, 16'd0};
    assign integ_v   = $signed({{(V_W-osp_pkg::INT_W){1'b0}}, integ_reg});
    assign quo_v     = $signed({2'b00, div_quo});
    assign lim_v     = $signed({{(V_W-osp_pkg::INT_W){1'b0}}, lim});
    assign integ_sum = err_reg[osp_pkg::ERR_W-1] ? integ_v - quo_v : integ_v + quo_v;
    always_comb begin
        if (cfg.ki == 16'd0 || integ_sum < 0) begin
            integ_new = '0;
        end else if (integ_sum > lim_v) begin
            integ_new = lim;
        end else begin
            integ_new = integ_sum[osp_pkg::INT_W-1:0];
        end
    end

    assign prod_s = $signed({1'b0, mul_prod[osp_pkg::PROD_W-2:0]});
    assign lim_s  = $signed({{(osp_pkg::SUM_W-osp_pkg::INT_W){1'b0}}, lim});

    // Rounding, start-current floor and command sign.
    assign rnd    = {1'b0, outq_reg} + 31'h0000_8000;
    assign mag    = rnd[30:16];
    assign mag_fl = (mag != '0 && mag < {1'b0, cfg.start}) ? {1'b0, cfg.start} : mag;
    assign cur    = cfg.neg_cmd ? -mag_fl : mag_fl;

    // Operand selection for the shared arithmetic units.
    always_comb begin
        unique case (state_reg)
            S_TGT: begin
                mul_mcand  = osp_pkg::MC_W'(sspeed_reg);
                mul_mplier = RATIO;
            end
            S_IMUL: begin
                mul_mcand  = osp_pkg::MC_W'(abs_err);
                mul_mplier = kidt_reg;
            end
            S_DMUL: begin
                mul_mcand  = osp_pkg::MC_W'(abs_diff);
                mul_mplier = osp_pkg::MP_W'(osp_pkg::MS_PER_S);
            end
            S_KD: begin
                mul_mcand  = div_quo[osp_pkg::MC_W-1:0];
                mul_mplier = osp_pkg::MP_W'(cfg.kd);
            end
            S_KP: begin
                mul_mcand  = osp_pkg::MC_W'(abs_err);
                mul_mplier = osp_pkg::MP_W'(cfg.kp);
            end
            default: begin
                mul_mcand  = '0;
                mul_mplier = '0;
            end
        endcase
    end
    assign div_divisor = (state_reg == S_IDIV) ? osp_pkg::MS_PER_S : dt_reg;

    // Tick sequencer.
    always_comb begin
        state_next      = state_reg;
        go_next         = go_reg;
        now_next        = now_reg;
        sspeed_next     = sspeed_reg;
        raw_next        = raw_reg;
        active_next     = active_reg;
        tgt_next        = tgt_reg;
        dt_next         = dt_reg;
        err_next        = err_reg;
        kidt_next       = kidt_reg;
        diff_next       = diff_reg;
        sum_next        = sum_reg;
        outq_next       = outq_reg;
        integ_next      = integ_reg;
        prev_err_next   = prev_err_reg;
        prev_tick_next  = prev_tick_reg;
        prev_valid_next = prev_valid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        mul_start       = 1'b0;
        div_start       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    now_next    = s_tdata[31:0];
                    sspeed_next = s_tdata[63:40];
                    raw_next    = s_tdata[79:64];
                    active_next = eng_in;
                    if (eng_in) begin
                        state_next = S_TGT;
                        go_next    = 1'b1;
                    end else begin
                        integ_next      = '0;
                        prev_err_next   = '0;
                        prev_tick_next  = '0;
                        prev_valid_next = 1'b0;
                        state_next      = S_FIN;
                    end
                end
            end
            S_TGT: begin
                if (go_reg) begin
                    mul_start = 1'b1;
                    go_next   = 1'b0;
                end else if (!mul_busy) begin
                    tgt_next   = tgt_sat;
                    dt_next    = dt_new;
                    state_next = S_ERR;
                end
            end
            S_ERR: begin
                err_next   = err_db;
                kidt_next  = osp_pkg::MP_W'(cfg.ki) * osp_pkg::MP_W'(dt_reg);
                state_next = S_IMUL;
                go_next    = 1'b1;
            end
            S_IMUL: begin
                if (go_reg) begin
                    mul_start = 1'b1;
                    go_next   = 1'b0;
                end else if (!mul_busy) begin
                    state_next = S_IDIV;
                    go_next    = 1'b1;
                end
            end
            S_IDIV: begin
                if (go_reg) begin
                    div_start = 1'b1;
                    go_next   = 1'b0;
                end else if (!div_busy) begin
                    integ_next = integ_new;
                    sum_next   = $signed({{(osp_pkg::SUM_W-osp_pkg::INT_W){1'b0}},
                                          integ_new});
                    diff_next  = $signed({err_reg[osp_pkg::ERR_W-1], err_reg})
                               - $signed({prev_err_reg[osp_pkg::ERR_W-1], prev_err_reg});
                    go_next    = 1'b1;
                    if (dt_reg == '0) begin
                        state_next = S_KP;
                    end else begin
                        state_next = S_DMUL;
                    end
                end
            end
            S_DMUL: begin
                if (go_reg) begin
                    mul_start = 1'b1;
                    go_next   = 1'b0;
                end else if (!mul_busy) begin
                    state_next = S_DDIV;
                    go_next    = 1'b1;
                end
            end
            S_DDIV: begin
                if (go_reg) begin
                    div_start = 1'b1;
                    go_next   = 1'b0;
                end else if (!div_busy) begin
                    state_next = S_KD;
                    go_next    = 1'b1;
                end
            end
            S_KD: begin
                if (go_reg) begin
                    mul_start = 1'b1;
                    go_next   = 1'b0;
                end else if (!mul_busy) begin
                    sum_next   = diff_reg[osp_pkg::DIFF_W-1] ? sum_reg - prod_s
                                                             : sum_reg + prod_s;
                    state_next = S_KP;
                    go_next    = 1'b1;
                end
            end
            S_KP: begin
                if (go_reg) begin
                    mul_start = 1'b1;
                    go_next   = 1'b0;
                end else if (!mul_busy) begin
                    sum_next   = err_reg[osp_pkg::ERR_W-1] ? sum_reg - prod_s
                                                           : sum_reg + prod_s;
                    state_next = S_CLMP;
                end
            end
            S_CLMP: begin
                if (sum_reg < 0) begin
                    outq_next = '0;
                end else if (sum_reg > lim_s) begin
                    outq_next = lim;
                end else begin
                    outq_next = sum_reg[osp_pkg::INT_W-1:0];
                end
                prev_err_next   = err_reg;
                prev_tick_next  = now_reg;
                prev_valid_next = 1'b1;
                state_next      = S_FIN;
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = active_reg;
                    if (active_reg) begin
                        m_tdata_next = {2'b00, tgt_reg, cur};
                    end else begin
                        m_tdata_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            go_reg         <= 1'b0;
            integ_reg      <= '0;
            prev_err_reg   <= '0;
            prev_tick_reg  <= '0;
            prev_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            go_reg         <= go_next;
            integ_reg      <= integ_next;
            prev_err_reg   <= prev_err_next;
            prev_tick_reg  <= prev_tick_next;
            prev_valid_reg <= prev_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        sspeed_reg  <= sspeed_next;
        raw_reg     <= raw_next;
        active_reg  <= active_next;
        tgt_reg     <= tgt_next;
        dt_reg      <= dt_next;
        err_reg     <= err_next;
        kidt_reg    <= kidt_next;
        diff_reg    <= diff_next;
        sum_reg     <= sum_next;
        outq_reg    <= outq_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The shared units never overlap.
    a_units_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_busy && div_busy))
        else $error("multiplier and divider busy together");

    // The multiplier is only started when it is free.
    a_mul_free: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_busy)
        else $error("multiplier restarted while busy");

    // A disengaged tick clears the PID state.
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !eng_in) |=> (!prev_valid_reg && integ_reg == '0))
        else $error("state not cleared on disengaged tick");

    // Disengaged results carry zero current.
    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[14:0] == 15'd0))
        else $error("nonzero current with assist off");

endmodule
